>>> hdl/multi_wave_mixer_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-wave mixer generator
// Immediate-cycle and next-cycle implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVE_MIXER_GENERATOR_UNIT_ASSERT_SVH
`define MULTI_WAVE_MIXER_GENERATOR_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define MWMG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mwmg: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define MWMG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mwmg: next-cycle check failed");

`endif

>>> hdl/mwmg_pkg.sv
// ----------------------------------------------------------------------------
// mwmg_pkg
// Widths, register indexes and the sine table of the multi-wave mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mwmg_pkg;

   // Period and phase
   localparam int TABLE_STEPS = 256;
   localparam int PHASE_W     = $clog2(TABLE_STEPS);

   // Field widths
   localparam int AMP_W    = 8;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_AMP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SINE_AMP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_AMP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_DUTY = 3'd3;

   // Fixed-point constants for the table build
   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   typedef logic signed [SAMPLE_W-1:0] sine_table_type [TABLE_STEPS];

   // Unsigned floor quotient by restoring long division, for the table build
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // round(32767 * sin(pi * k / 128)) for k in 0..64, Q30 Taylor series
   function automatic logic [15:0] quarter_sine_f(input logic [7:0] k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      logic [63:0] divisor;
      x    = (PI_Q30 * {56'd0, k}) >> 7;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 12; n++) begin
         divisor = 64'((2 * n) * (2 * n + 1));
         term    = udiv64((term * x2) >> 30, divisor);
         if ((n & 1) == 1) begin
            sum = (sum > term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      v = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[15:0];
   endfunction

   // Full-period table mirrored from the quarter wave
   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [7:0]     h;
      logic [7:0]     k;
      logic [15:0]    v;
      for (int i = 0; i < TABLE_STEPS; i++) begin
         h = 8'(i & 127);
         k = (h <= 8'd64) ? h : 8'd128 - h;
         v = quarter_sine_f(k);
         tbl[i] = (i >= 128) ? -$signed(v) : $signed(v);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_ROM = build_sine_table();

endpackage

`default_nettype wire

>>> hdl/multi_wave_mixer_generator_unit.sv
`timescale 1ns / 1ps
// An accepted request word passes the phase stage and then the response register.
// Throughput: one word per cycle while rsp_ready is high; the response register
// and the phase stage form a two-deep pipeline, so a new word enters while a response waits.
// The sine ROM lookup, the 16x9 sine multiply and the three-term add set the path.
// Reset (synchronous, active high) clears the phase, the amplitude and duty
// registers and both valid flags; no word is taken while reset is high.
// ----------------------------------------------------------------------------
// multi_wave_mixer_generator_unit
// Ramp, sine and pulse oscillator over a 256-step period, mixed and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_wave_mixer_generator_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_restart,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [mwmg_pkg::SAMPLE_W-1:0]       rsp_sample,
   output logic                                       rsp_clipped,
   output logic [mwmg_pkg::PHASE_W-1:0]               rsp_phase,
   output logic                                       rsp_period_end,
   input  wire logic                                  csr_wr_en,
   input  wire logic [mwmg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [mwmg_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mwmg_pkg::*;

`include "multi_wave_mixer_generator_unit_assert.svh"

   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TABLE_STEPS - 1);
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

   // Configuration registers
   logic [AMP_W-1:0] ramp_amp_ff, sine_amp_ff, pulse_amp_ff, pulse_duty_ff;

   // Phase counter and stage-one word
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PHASE_W-1:0] s1_phase_ff, s1_phase_in;
   logic               s1_valid_ff, s1_valid_in;

   // Response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_clipped_ff, rsp_clipped_in;
   logic [PHASE_W-1:0]         rsp_phase_ff;
   logic                       rsp_period_end_ff;

   logic req_accept;
   logic out_advance;

   // Mixer datapath
   logic signed [PHASE_W:0]       ramp_offset;
   logic signed [AMP_W:0]         ramp_gain;
   logic signed [SUM_W-1:0]       ramp_term;
   logic signed [SAMPLE_W+AMP_W:0] sine_prod;
   logic signed [SAMPLE_W+AMP_W:0] sine_bias;
   logic signed [SUM_W-1:0]       sine_term;
   logic signed [SUM_W-1:0]       pulse_mag;
   logic signed [SUM_W-1:0]       pulse_term;
   logic signed [SUM_W-1:0]       mix_sum;

   // Write configuration; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_amp_ff   <= '0;
         sine_amp_ff   <= '0;
         pulse_amp_ff  <= '0;
         pulse_duty_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RAMP_AMP:   ramp_amp_ff   <= csr_wdata[AMP_W-1:0];
            CSR_SINE_AMP:   sine_amp_ff   <= csr_wdata[AMP_W-1:0];
            CSR_PULSE_AMP:  pulse_amp_ff  <= csr_wdata[AMP_W-1:0];
            CSR_PULSE_DUTY: pulse_duty_ff <= csr_wdata[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: advance when the response slot is free or being taken
   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !reset && (!s1_valid_ff || out_advance);
   assign req_accept  = req_valid && req_ready;

   // Pick the phase for this word and advance the counter
   always_comb begin
      s1_phase_in = req_restart ? '0 : phase_ff;
      phase_in    = phase_ff;
      s1_valid_in = s1_valid_ff && !out_advance;
      if (req_accept) begin
         phase_in    = s1_phase_in + 1'b1;
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_phase_ff <= s1_phase_in;
      end
   end

   // Mix the three terms and saturate
   always_comb begin
      ramp_offset = $signed({1'b0, s1_phase_ff}) - $signed((PHASE_W + 1)'(127));
      ramp_gain   = $signed({1'b0, ramp_amp_ff});
      ramp_term   = SUM_W'(ramp_offset) * SUM_W'(ramp_gain);

      // S * amp / 256, truncated toward zero
      sine_prod = SINE_ROM[s1_phase_ff] * $signed({1'b0, sine_amp_ff});
      sine_bias = sine_prod[SAMPLE_W+AMP_W] ? sine_prod + (SAMPLE_W + AMP_W + 1)'(255)
                                            : sine_prod;
      sine_term = SUM_W'(sine_bias >>> 8);

      pulse_mag  = $signed(SUM_W'({pulse_amp_ff, 7'd0}));
      pulse_term = (s1_phase_ff < pulse_duty_ff) ? pulse_mag : -pulse_mag;

      mix_sum = ramp_term + sine_term + pulse_term;

      rsp_clipped_in = 1'b0;
      rsp_sample_in  = mix_sum[SAMPLE_W-1:0];
      if (mix_sum > SAT_MAX) begin
         rsp_sample_in  = SAT_MAX[SAMPLE_W-1:0];
         rsp_clipped_in = 1'b1;
      end else if (mix_sum < SAT_MIN) begin
         rsp_sample_in  = SAT_MIN[SAMPLE_W-1:0];
         rsp_clipped_in = 1'b1;
      end
   end

   // Hold or load the response word
   always_comb begin
      rsp_valid_in = out_advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance && s1_valid_ff) begin
         rsp_sample_ff     <= rsp_sample_in;
         rsp_clipped_ff    <= rsp_clipped_in;
         rsp_phase_ff      <= s1_phase_ff;
         rsp_period_end_ff <= (s1_phase_ff == PHASE_LAST);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;
   assign rsp_phase      = rsp_phase_ff;
   assign rsp_period_end = rsp_period_end_ff;

   // Checks
   `MWMG_ASSERT_NEXT(a_restart_zero, clock, reset, req_accept && req_restart,
                     s1_phase_ff == '0)
   `MWMG_ASSERT_NEXT(a_phase_follow, clock, reset, req_accept && !req_restart,
                     s1_phase_ff == $past(phase_ff))
   `MWMG_ASSERT_SAME(a_clip_rail, clock, reset, rsp_valid_ff && rsp_clipped_ff,
                     rsp_sample_ff == SAT_MAX[SAMPLE_W-1:0] ||
                     rsp_sample_ff == SAT_MIN[SAMPLE_W-1:0])
   `MWMG_ASSERT_SAME(a_period_end, clock, reset, rsp_valid_ff,
                     rsp_period_end_ff == (rsp_phase_ff == PHASE_LAST))

endmodule

`default_nettype wire
